>>> design/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants for the LIFO stack with search/remove
// Operation codes, result-select codes, and the command, status and
// result structures passed between the controller, datapath and response buffer.
// ----------------------------------------------------------------------------
package lsr_pkg;

   localparam int LSR_STACK_DEPTH = 64;
   localparam int LSR_WORD_W      = 32;
   localparam int LSR_CNT_OUT_W   = 7;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      RES_ACCEPT = 2'd0,
      RES_POP    = 2'd1,
      RES_SEARCH = 2'd2
   } res_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_POP    = 2'd1,
      ST_SEARCH = 2'd2
   } state_type;

   typedef struct packed {
      logic        start;
      mode_type    mode;
      logic        scan;
      res_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic scan_done;
   } status_type;

   typedef struct packed {
      logic signed [LSR_WORD_W-1:0]    popped_value;
      logic                            found;
      logic        [LSR_CNT_OUT_W-1:0] position;
      logic        [LSR_CNT_OUT_W-1:0] entry_total;
      logic                            fault;
   } result_type;

endpackage

>>> design/lsr_ctrl.sv
// ----------------------------------------------------------------------------
// lsr_ctrl: operation sequencer
// Accepts request beats, starts each operation in the datapath, steps the
// search walk and signals when a result beat is ready for the response buffer.
// ----------------------------------------------------------------------------
module lsr_ctrl
   import lsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  status_type status,
   input  logic       hold_full,
   output cmd_type    cmd,
   output logic       res_fire
);

   state_type state_ff;
   state_type state_in;
   mode_type  mode;
   logic      accept;

   assign mode   = mode_type'(req_mode);
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      res_fire  = 1'b0;
      cmd.start = 1'b0;
      cmd.mode  = mode;
      cmd.scan  = 1'b0;
      cmd.sel   = RES_ACCEPT;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !hold_full;
            if (accept) begin
               cmd.start = 1'b1;
               unique case (mode)
                  MODE_PUSH, MODE_CLEAR: begin
                     res_fire = 1'b1;
                  end
                  MODE_POP: begin
                     // empty pop answers at once with a fault
                     if (status.empty) begin
                        res_fire = 1'b1;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  MODE_SEARCH: begin
                     state_in = ST_SEARCH;
                  end
               endcase
            end
         end
         ST_POP: begin
            cmd.sel  = RES_POP;
            res_fire = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            cmd.sel  = RES_SEARCH;
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               res_fire = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/lsr_datapath.sv
// ----------------------------------------------------------------------------
// lsr_datapath: stack storage, entry count and search/compaction walk
// The walk reads bottom-up one entry per cycle and writes survivors down to
// the keep index, so the order of the survivors is preserved in place.
// ----------------------------------------------------------------------------
module lsr_datapath
   import lsr_pkg::*;
#(
   parameter int STACK_DEPTH = LSR_STACK_DEPTH
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic signed [LSR_WORD_W-1:0] req_value,
   output status_type                   status,
   output result_type                   result
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   logic [LSR_WORD_W-1:0] stack_mem [STACK_DEPTH];

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LSR_WORD_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [CNT_W-1:0]      keep_ff, keep_in;
   logic [CNT_W-1:0]      first_keep_ff, first_keep_in;
   logic                  found_ff, found_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [LSR_WORD_W-1:0] rd_data_ff;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [LSR_WORD_W-1:0] wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [CNT_W-1:0]      count_dec;
   logic                  full;
   logic                  empty;
   logic                  scan_done;
   logic [CNT_W-1:0]      pos_cnt;
   logic [CNT_W+LSR_CNT_OUT_W-1:0] total_wide;
   logic [CNT_W+LSR_CNT_OUT_W-1:0] pos_wide;

   assign count_dec = count_ff - 1'b1;
   assign full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign empty     = (count_ff == '0);
   assign scan_done = (scan_ff == count_ff) && !cmp_valid_ff;

   assign status.empty     = empty;
   assign status.scan_done = scan_done;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      scan_ff       <= scan_in;
      keep_ff       <= keep_in;
      first_keep_ff <= first_keep_in;
      found_ff      <= found_in;
   end

   always_comb begin
      count_in      = count_ff;
      key_in        = key_ff;
      scan_in       = scan_ff;
      keep_in       = keep_ff;
      first_keep_in = first_keep_ff;
      found_in      = found_ff;
      cmp_valid_in  = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = keep_ff[ADDR_W-1:0];
      wr_data       = rd_data_ff;
      rd_addr       = scan_ff[ADDR_W-1:0];

      if (cmd.start) begin
         unique case (cmd.mode)
            MODE_PUSH: begin
               if (!full) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  wr_data  = req_value;
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_POP: begin
               if (!empty) begin
                  rd_addr  = count_dec[ADDR_W-1:0];
                  count_in = count_dec;
               end
            end
            MODE_SEARCH: begin
               key_in        = req_value;
               scan_in       = '0;
               keep_in       = '0;
               first_keep_in = '0;
               found_in      = 1'b0;
            end
            MODE_CLEAR: begin
               count_in = '0;
            end
         endcase
      end

      // issue the next read of the walk
      if (cmd.scan && (scan_ff != count_ff)) begin
         cmp_valid_in = 1'b1;
         scan_in      = scan_ff + 1'b1;
      end

      // compare the entry read last cycle: move survivors down, note the first hit
      if (cmp_valid_ff) begin
         if (rd_data_ff != key_ff) begin
            wr_en   = 1'b1;
            keep_in = keep_ff + 1'b1;
         end else if (!found_ff) begin
            found_in      = 1'b1;
            first_keep_in = keep_ff;
         end
      end

      if (cmd.scan && scan_done) begin
         count_in = keep_ff;
      end
   end

   // survivors above the deepest match, plus one
   assign pos_cnt    = keep_ff - first_keep_ff + 1'b1;
   assign total_wide = {{LSR_CNT_OUT_W{1'b0}}, count_in};
   assign pos_wide   = {{LSR_CNT_OUT_W{1'b0}}, pos_cnt};

   always_comb begin
      result              = '0;
      result.entry_total  = total_wide[LSR_CNT_OUT_W-1:0];
      unique case (cmd.sel)
         RES_ACCEPT: begin
            result.fault = ((cmd.mode == MODE_PUSH) && full) ||
                           ((cmd.mode == MODE_POP) && empty);
         end
         RES_POP: begin
            result.popped_value = rd_data_ff;
         end
         RES_SEARCH: begin
            result.found    = found_ff;
            result.position = found_ff ? pos_wide[LSR_CNT_OUT_W-1:0] : '0;
         end
         default: begin
            result.fault = 1'b0;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("entry count exceeds stack depth");

   a_keep_behind_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (keep_ff < scan_ff))
      else $error("compaction write would overtake the read index");

   a_no_start_mid_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !cmp_valid_ff)
      else $error("new operation started while a compare is in flight");

endmodule

>>> design/lsr_resp_buf.sv
// ----------------------------------------------------------------------------
// lsr_resp_buf: response output register with one skid entry
// Lets the sequencer finish an operation while the previous response beat is
// still waiting for the consumer.
// ----------------------------------------------------------------------------
module lsr_resp_buf
   import lsr_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            res_fire,
   input  result_type                      result,
   output logic                            hold_full,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [LSR_WORD_W-1:0]    rsp_popped_value,
   output logic                            rsp_found,
   output logic        [LSR_CNT_OUT_W-1:0] rsp_position,
   output logic        [LSR_CNT_OUT_W-1:0] rsp_entry_total,
   output logic                            rsp_fault
);

   logic       out_valid_ff, out_valid_in;
   logic       hold_valid_ff, hold_valid_in;
   result_type out_ff, out_in;
   result_type hold_ff, hold_in;
   logic       slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      hold_in       = hold_ff;
      if (hold_valid_ff) begin
         // drain the skid entry first
         if (slot_free) begin
            out_in        = hold_ff;
            out_valid_in  = 1'b1;
            hold_valid_in = 1'b0;
         end
      end else if (res_fire) begin
         if (slot_free) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            hold_in       = result;
            hold_valid_in = 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign hold_full        = hold_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_popped_value = out_ff.popped_value;
   assign rsp_found        = out_ff.found;
   assign rsp_position     = out_ff.position;
   assign rsp_entry_total  = out_ff.entry_total;
   assign rsp_fault        = out_ff.fault;

   a_fire_needs_room: assert property (@(posedge clock) disable iff (reset)
      res_fire |-> !hold_valid_ff)
      else $error("result produced while skid entry is occupied");

   a_hold_behind_out: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> out_valid_ff)
      else $error("skid entry holds data while output register is empty");

endmodule

>>> design/lifo_stack_search_remove.sv
// ----------------------------------------------------------------------------
// lifo_stack_search_remove: bounded LIFO stack with search-and-remove
// Top level: sequencer, datapath with stack memory, and response buffer.
// ----------------------------------------------------------------------------
// Each request beat carries one operation and yields exactly one response beat.
// Push, clear and pop on an empty stack are answered in the cycle they are
// accepted; a pop answers from the ST_POP state, once the stack memory's
// registered read port has delivered the top entry. Search and remove walks
// the entries held: it reads one entry a cycle through that same port,
// compares it with the key in the next cycle and writes each survivor down
// in place, so the entries keep their order. A push on a full stack and a
// pop on an empty one leave the stack as it is and set rsp_fault. A finished
// response waits in a one-entry skid buffer, so the next request beat is
// taken while the previous response beat is still pending.
// ----------------------------------------------------------------------------
module lifo_stack_search_remove
   import lsr_pkg::*;
#(
   parameter int STACK_DEPTH = LSR_STACK_DEPTH
)
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic        [1:0]               req_mode,
   input  logic signed [LSR_WORD_W-1:0]    req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [LSR_WORD_W-1:0]    rsp_popped_value,
   output logic                            rsp_found,
   output logic        [LSR_CNT_OUT_W-1:0] rsp_position,
   output logic        [LSR_CNT_OUT_W-1:0] rsp_entry_total,
   output logic                            rsp_fault
);

   cmd_type    cmd;
   status_type status;
   result_type result;
   logic       res_fire;
   logic       hold_full;

   lsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .status    (status),
      .hold_full (hold_full),
      .cmd       (cmd),
      .res_fire  (res_fire)
   );

   lsr_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_value (req_value),
      .status    (status),
      .result    (result)
   );

   lsr_resp_buf u_resp_buf (
      .clock            (clock),
      .reset            (reset),
      .res_fire         (res_fire),
      .result           (result),
      .hold_full        (hold_full),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .rsp_entry_total  (rsp_entry_total),
      .rsp_fault        (rsp_fault)
   );

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression for the LIFO stack with search-and-remove
// Drives push, pop, search-and-remove and clear requests with random gaps and
// response stalls. A shadow copy of the stack predicts each response beat, and
// every beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
import lsr_pkg::*;

class stack_mirror;
   logic signed [LSR_WORD_W-1:0] words [LSR_STACK_DEPTH];
   int                           depth_held;
   result_type                   due_results [$];
   int                           errors;
   int                           checked;
   int                           push_faults;
   int                           pop_faults;
   int                           search_hits;
   int                           search_misses;

   function new();
      depth_held    = 0;
      errors        = 0;
      checked       = 0;
      push_faults   = 0;
      pop_faults    = 0;
      search_hits   = 0;
      search_misses = 0;
   endfunction

   // Apply one accepted request beat to the shadow stack and queue its response.
   function void apply_op(mode_type mode, logic signed [LSR_WORD_W-1:0] value);
      result_type r;
      int         above;
      int         keep;
      int         i;
      r = '0;
      case (mode)
         MODE_PUSH: begin
            if (depth_held >= LSR_STACK_DEPTH) begin
               r.fault = 1'b1;
               push_faults++;
            end else begin
               words[depth_held] = value;
               depth_held++;
            end
         end
         MODE_POP: begin
            if (depth_held == 0) begin
               r.fault = 1'b1;
               pop_faults++;
            end else begin
               depth_held--;
               r.popped_value = words[depth_held];
            end
         end
         MODE_SEARCH: begin
            // walk down from the top; the last hit seen is the deepest one
            above = 1;
            for (i = depth_held - 1; i >= 0; i--) begin
               if (words[i] != value) begin
                  above++;
               end else begin
                  r.found    = 1'b1;
                  r.position = 7'(above);
               end
            end
            if (r.found) begin
               keep = 0;
               for (i = 0; i < depth_held; i++) begin
                  if (words[i] != value) begin
                     words[keep] = words[i];
                     keep++;
                  end
               end
               depth_held = keep;
               search_hits++;
            end else begin
               search_misses++;
            end
         end
         MODE_CLEAR: begin
            depth_held = 0;
         end
      endcase
      r.entry_total = 7'(depth_held);
      due_results.push_back(r);
   endfunction

   function void compare_field(string field, longint want, longint seen);
      if (want != seen) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch on response %0d: expected %0d, actual %0d",
                     $time, field, checked, want, seen);
      end
   endfunction

   function void check_result(result_type got);
      result_type want;
      if (due_results.size() == 0) begin
         errors++;
         if (errors <= 40)
            $display("%0t: response beat with nothing expected: expected none, actual %p",
                     $time, got);
         return;
      end
      want = due_results.pop_front();
      compare_field("popped_value", want.popped_value, got.popped_value);
      compare_field("found", want.found, got.found);
      compare_field("position", want.position, got.position);
      compare_field("entry_total", want.entry_total, got.entry_total);
      compare_field("fault", want.fault, got.fault);
      checked++;
   endfunction
endclass

module tb_top;
   import lsr_pkg::*;

   localparam int RANDOM_ITEMS = 1350;
   localparam int SETTLE_CYCLES = 20;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   mode_type                        req_mode;
   logic signed [LSR_WORD_W-1:0]    req_value;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic signed [LSR_WORD_W-1:0]    rsp_popped_value;
   logic                            rsp_found;
   logic        [LSR_CNT_OUT_W-1:0] rsp_position;
   logic        [LSR_CNT_OUT_W-1:0] rsp_entry_total;
   logic                            rsp_fault;

   stack_mirror                  mirror = new();
   logic signed [LSR_WORD_W-1:0] word_pool [8];
   bit                           gapless;
   int                           random_sent;
   int                           full_visits;

   lifo_stack_search_remove dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .rsp_entry_total  (rsp_entry_total),
      .rsp_fault        (rsp_fault)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1500000;
      $display("lifo_stack_search_remove regression: fail");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (gapless || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic signed [LSR_WORD_W-1:0] pick_word(int pool_pct);
      if ($urandom_range(0, 99) < pool_pct)
         return word_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Refill the pool of likely keys, seeding it with the extremes now and then.
   task automatic refresh_pool();
      int i;
      for (i = 0; i < 8; i++) begin
         case ($urandom_range(0, 7))
            0:       word_pool[i] = 32'sh8000_0000;
            1:       word_pool[i] = 32'sh7fff_ffff;
            2:       word_pool[i] = '0;
            3:       word_pool[i] = -1;
            default: word_pool[i] = $urandom;
         endcase
      end
   endtask

   // Present one request beat, hold it until taken, then update the mirror.
   task automatic send_request(mode_type mode, logic signed [LSR_WORD_W-1:0] value);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      mirror.apply_op(mode, value);
      if (mode == MODE_PUSH && mirror.depth_held == LSR_STACK_DEPTH)
         full_visits++;
   endtask

   task automatic mixed_burst();
      int       count;
      int       roll;
      mode_type mode;
      count = $urandom_range(10, 60);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 45)
            mode = MODE_PUSH;
         else if (roll < 68)
            mode = MODE_POP;
         else if (roll < 96)
            mode = MODE_SEARCH;
         else
            mode = MODE_CLEAR;
         send_request(mode, pick_word(mode == MODE_SEARCH ? 75 : 55));
         random_sent++;
      end
   endtask

   // Push until full, knock on the full stack, then search the duplicates out.
   task automatic fill_burst();
      while (mirror.depth_held < LSR_STACK_DEPTH) begin
         send_request(MODE_PUSH, pick_word(80));
         random_sent++;
      end
      repeat ($urandom_range(1, 3)) begin
         send_request(MODE_PUSH, pick_word(50));
         random_sent++;
      end
      repeat ($urandom_range(1, 4)) begin
         send_request(MODE_SEARCH, pick_word(85));
         random_sent++;
      end
   endtask

   task automatic drain_burst();
      while (mirror.depth_held > 0) begin
         send_request(MODE_POP, pick_word(0));
         random_sent++;
      end
      repeat ($urandom_range(1, 2)) begin
         send_request(MODE_POP, pick_word(0));
         random_sent++;
      end
   endtask

   task automatic directed_items();
      send_request(MODE_POP, 32'sd0);
      send_request(MODE_SEARCH, 32'sd5);
      send_request(MODE_PUSH, 32'sh7fff_ffff);
      send_request(MODE_PUSH, 32'sh8000_0000);
      send_request(MODE_PUSH, -32'sd1);
      send_request(MODE_PUSH, 32'sd0);
      send_request(MODE_PUSH, -32'sd1);
      send_request(MODE_PUSH, 32'sh8000_0000);
      send_request(MODE_SEARCH, 32'sd5);
      send_request(MODE_SEARCH, -32'sd1);
      send_request(MODE_POP, 32'sd0);
      send_request(MODE_SEARCH, 32'sh7fff_ffff);
      send_request(MODE_POP, 32'sd0);
      send_request(MODE_POP, 32'sd0);
      send_request(MODE_POP, 32'sd0);
      send_request(MODE_PUSH, 32'sh5555_aaaa);
      send_request(MODE_PUSH, 32'shaaaa_5555);
      send_request(MODE_CLEAR, -32'sd1);
      send_request(MODE_POP, 32'sd0);
      send_request(MODE_PUSH, 32'sd1);
      send_request(MODE_SEARCH, 32'sd1);
      send_request(MODE_CLEAR, 32'sd0);
   endtask

   // Response side: alternate ready and stall runs of random length.
   initial begin
      int   run;
      logic level;
      rsp_ready = 1'b0;
      level     = 1'b0;
      run       = 0;
      forever begin
         @(negedge clock);
         if (run == 0) begin
            level = !level;
            if (level)
               run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
            else if ($urandom_range(0, 9) < 7)
               run = $urandom_range(1, 2);
            else if ($urandom_range(0, 2) < 2)
               run = $urandom_range(3, 6);
            else
               run = $urandom_range(10, 30);
         end
         rsp_ready <= level;
         run--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         mirror.check_result(result_type'({rsp_popped_value, rsp_found, rsp_position,
                                           rsp_entry_total, rsp_fault}));
   end

   initial begin
      int kind;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_mode    = MODE_PUSH;
      req_value   = '0;
      gapless     = 1'b0;
      random_sent = 0;
      full_visits = 0;
      refresh_pool();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_items();

      // first random segment fills the stack so the full case is always hit
      kind = 0;
      while (random_sent < RANDOM_ITEMS) begin
         gapless = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 2) == 0)
            refresh_pool();
         if (kind == 0)
            fill_burst();
         else if (kind == 1)
            drain_burst();
         else
            mixed_burst();
         kind = ($urandom_range(0, 9) < 2) ? 0 : ($urandom_range(0, 9) < 2) ? 1 : 2;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (mirror.due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d responses: %0d full-stack pushes, %0d empty pops, %0d faulted pushes",
               mirror.checked, full_visits, mirror.pop_faults, mirror.push_faults);
      $display("Searches with a hit: %0d, without: %0d; mismatches: %0d",
               mirror.search_hits, mirror.search_misses, mirror.errors);
      if (mirror.errors == 0)
         $display("lifo_stack_search_remove regression: pass");
      else
         $display("lifo_stack_search_remove regression: fail");
      $finish;
   end

endmodule
